// File: hw/rtl/flash_backup_command_engine_top_defines.svh
// Assertion macros shared by the flash backup command engine RTL.
`ifndef FLASH_BACKUP_COMMAND_ENGINE_TOP_DEFINES_SVH
`define FLASH_BACKUP_COMMAND_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FBCE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FBCE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/fbce_pkg.sv
// Package with types, codes and defaults of the flash backup command engine.
`timescale 1ns / 1ps

package fbce_pkg;

    // Default geometry.
    localparam int SECTOR_BYTES_DEF = 4096;
    localparam int BANK_COUNT_DEF   = 2;
    localparam int BANK_BYTES       = 65536;

    // Register reset values.
    localparam logic [7:0] MFR_ID_RST = 8'h62;
    localparam logic [7:0] DEV_ID_RST = 8'h13;

    // Register indexes on the configuration port.
    localparam logic REG_MFR_ID = 1'b0;
    localparam logic REG_DEV_ID = 1'b1;

    // Command addresses and bytes.
    localparam logic [15:0] ADDR_CMD1  = 16'h5555;
    localparam logic [15:0] ADDR_CMD2  = 16'h2AAA;
    localparam logic [15:0] ADDR_ZERO  = 16'h0000;
    localparam logic [15:0] ADDR_ONE   = 16'h0001;
    localparam logic [7:0]  BYTE_PRO1  = 8'hAA;
    localparam logic [7:0]  BYTE_PRO2  = 8'h55;
    localparam logic [7:0]  CMD_ID_IN  = 8'h90;
    localparam logic [7:0]  CMD_ID_OUT = 8'hF0;
    localparam logic [7:0]  CMD_CHIP   = 8'h10;
    localparam logic [7:0]  CMD_PROG   = 8'hA0;
    localparam logic [7:0]  CMD_BANK   = 8'hB0;
    localparam logic [7:0]  ERASED     = 8'hFF;

    // Bus access kinds.
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Command sequencer phase.
    typedef enum logic [2:0] {
        PH_READY     = 3'd0,
        PH_PROLOGUE  = 3'd1,
        PH_OPERATION = 3'd2,
        PH_PROGRAM   = 3'd3,
        PH_BANK      = 3'd4
    } phase_t;

    // Control state of the engine.
    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_READ  = 2'd2,
        ST_ERASE = 2'd3
    } state_t;

    // Source of a read result.
    typedef enum logic [1:0] {
        RSEL_MEM = 2'd0,
        RSEL_MFR = 2'd1,
        RSEL_DEV = 2'd2
    } rsel_t;

endpackage

// File: hw/rtl/flash_backup_command_engine_top.sv
// Top level of the flash backup command engine: command sequencer and storage.
`timescale 1ns / 1ps
// Usage:
// The s_ stream carries bus accesses (read or write with a 16-bit address and a data
// byte); every accepted transfer yields exactly one m_ transfer with the read byte and
// the prologue error flag, in order. The APB port sets the two ID bytes.
// Storage is one byte-wide synchronous RAM of BANK_COUNT*64K bytes, one access a cycle.
// A read passes the RAM read register, then the result register. A write's result is
// registered at once; a sector erase then sweeps SECTOR_BYTES bytes and a chip erase
// BANK_COUNT*65536 bytes, one byte per cycle, with s_tready low meanwhile.
// After reset the same sweep writes 0xFF over the whole RAM, all BANK_COUNT*65536 bytes
// (131072 at the defaults), before the first transfer is accepted; APB writes are taken
// throughout. A new transfer is accepted only when the result register is empty or is
// being taken in the same cycle, so a stalled receiver holds the input side off; the
// result stays stable until m_tready is seen.
`include "flash_backup_command_engine_top_defines.svh"

module flash_backup_command_engine_top #(
    parameter int SECTOR_BYTES = fbce_pkg::SECTOR_BYTES_DEF,
    parameter int BANK_COUNT   = fbce_pkg::BANK_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream; tdata: [0] func, [16:1] addr, [24:17] write_data.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // Result stream; tdata: [7:0] read_data, [8] cmd_error.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int MEM_DEPTH = BANK_COUNT * fbce_pkg::BANK_BYTES;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam logic [15:0]       SECT_MASK = 16'(SECTOR_BYTES - 1);
    localparam logic [MEM_AW-1:0] BANK1_OFF = MEM_AW'(fbce_pkg::BANK_BYTES);
    localparam logic [MEM_AW-1:0] MEM_LAST  = MEM_AW'(MEM_DEPTH - 1);

    // Input fields.
    logic        in_func;
    logic [15:0] in_addr;
    logic [7:0]  in_wdata;
    assign in_func  = s_tdata[0];
    assign in_addr  = s_tdata[16:1];
    assign in_wdata = s_tdata[24:17];

    // State registers.
    fbce_pkg::state_t state_reg, state_next;
    fbce_pkg::phase_t phase_reg, phase_next;
    fbce_pkg::rsel_t  rsel_reg, rsel_next;
    logic              id_mode_reg, id_mode_next;
    logic              bank_reg, bank_next;
    logic [MEM_AW-1:0] sweep_addr_reg, sweep_addr_next;
    logic [MEM_AW-1:0] sweep_last_reg, sweep_last_next;
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        m_rdata_reg, m_rdata_next;
    logic              m_err_reg, m_err_next;
    logic [7:0]        mfr_id_reg, dev_id_reg;

    // Memory signals.
    logic [7:0]        mem [MEM_DEPTH];
    logic [7:0]        mem_rd_reg;
    logic              mem_we, mem_re;
    logic [MEM_AW-1:0] mem_addr;
    logic [7:0]        mem_wdata;

    // Handshake and decoded write effects.
    logic              in_xfer, wr_xfer;
    logic              wr_err, do_chip, do_sector, do_prog;
    logic [MEM_AW-1:0] bank_off, item_addr, sect_base;

    assign bank_off  = (BANK_COUNT > 1 && bank_reg) ? BANK1_OFF : '0;
    assign item_addr = bank_off | MEM_AW'(in_addr);
    assign sect_base = bank_off | MEM_AW'(in_addr & ~SECT_MASK);
    assign in_xfer   = s_tvalid && s_tready;
    assign wr_xfer   = in_xfer && (in_func == fbce_pkg::FUNC_WRITE);

    // Command decode of a write against the current phase.
    always_comb begin
        phase_next   = phase_reg;
        id_mode_next = id_mode_reg;
        bank_next    = bank_reg;
        wr_err       = 1'b0;
        do_chip      = 1'b0;
        do_sector    = 1'b0;
        do_prog      = 1'b0;
        unique case (phase_reg)
            fbce_pkg::PH_READY: begin
                if (in_addr == fbce_pkg::ADDR_CMD1) begin
                    if (in_wdata != fbce_pkg::BYTE_PRO1) begin
                        wr_err = 1'b1;
                    end else begin
                        phase_next = fbce_pkg::PH_PROLOGUE;
                    end
                end
            end
            fbce_pkg::PH_PROLOGUE: begin
                if (in_addr == fbce_pkg::ADDR_CMD2) begin
                    if (in_wdata != fbce_pkg::BYTE_PRO2) begin
                        wr_err = 1'b1;
                    end else begin
                        phase_next = fbce_pkg::PH_OPERATION;
                    end
                end
            end
            fbce_pkg::PH_OPERATION: begin
                if (in_addr == fbce_pkg::ADDR_CMD1) begin
                    phase_next = fbce_pkg::PH_READY;
                    case (in_wdata)
                        fbce_pkg::CMD_ID_IN:  id_mode_next = 1'b1;
                        fbce_pkg::CMD_ID_OUT: id_mode_next = 1'b0;
                        fbce_pkg::CMD_CHIP:   do_chip = 1'b1;
                        fbce_pkg::CMD_PROG:   phase_next = fbce_pkg::PH_PROGRAM;
                        fbce_pkg::CMD_BANK:   phase_next = fbce_pkg::PH_BANK;
                        default:              phase_next = fbce_pkg::PH_READY;
                    endcase
                end else if ((in_addr & SECT_MASK) == '0) begin
                    do_sector  = 1'b1;
                    phase_next = fbce_pkg::PH_READY;
                end
            end
            fbce_pkg::PH_PROGRAM: begin
                do_prog    = 1'b1;
                phase_next = fbce_pkg::PH_READY;
            end
            fbce_pkg::PH_BANK: begin
                if (in_addr == fbce_pkg::ADDR_ZERO) begin
                    bank_next  = (BANK_COUNT > 1) ? in_wdata[0] : 1'b0;
                    phase_next = fbce_pkg::PH_READY;
                end
            end
            default: phase_next = fbce_pkg::PH_READY;
        endcase
    end

    // Next control state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg) inside
            fbce_pkg::ST_CLEAR,
            fbce_pkg::ST_ERASE: begin
                if (sweep_addr_reg == sweep_last_reg) begin
                    state_next = fbce_pkg::ST_IDLE;
                end
            end
            fbce_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if (in_func == fbce_pkg::FUNC_READ) begin
                        state_next = fbce_pkg::ST_READ;
                    end else if (do_chip) begin
                        state_next = fbce_pkg::ST_CLEAR;
                    end else if (do_sector) begin
                        state_next = fbce_pkg::ST_ERASE;
                    end
                end
            end
            fbce_pkg::ST_READ: state_next = fbce_pkg::ST_IDLE;
            default:           state_next = fbce_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the control state: handshake, memory port, sweep and result loads.
    always_comb begin
        s_tready        = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_addr        = item_addr;
        mem_wdata       = in_wdata;
        sweep_addr_next = sweep_addr_reg;
        sweep_last_next = sweep_last_reg;
        rsel_next       = rsel_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_rdata_next    = m_rdata_reg;
        m_err_next      = m_err_reg;
        unique case (state_reg) inside
            fbce_pkg::ST_CLEAR,
            fbce_pkg::ST_ERASE: begin
                mem_we          = 1'b1;
                mem_addr        = sweep_addr_reg;
                mem_wdata       = fbce_pkg::ERASED;
                sweep_addr_next = sweep_addr_reg + MEM_AW'(1);
            end
            fbce_pkg::ST_IDLE: begin
                s_tready = !m_valid_reg || m_tready;
                if (s_tvalid && s_tready && in_func == fbce_pkg::FUNC_READ) begin
                    mem_re = 1'b1;
                    if (id_mode_reg && in_addr == fbce_pkg::ADDR_ZERO) begin
                        rsel_next = fbce_pkg::RSEL_MFR;
                    end else if (id_mode_reg && in_addr == fbce_pkg::ADDR_ONE) begin
                        rsel_next = fbce_pkg::RSEL_DEV;
                    end else begin
                        rsel_next = fbce_pkg::RSEL_MEM;
                    end
                end else if (s_tvalid && s_tready) begin
                    mem_we       = do_prog;
                    m_valid_next = 1'b1;
                    m_rdata_next = '0;
                    m_err_next   = wr_err;
                    if (do_chip) begin
                        sweep_addr_next = '0;
                        sweep_last_next = MEM_LAST;
                    end else if (do_sector) begin
                        sweep_addr_next = sect_base;
                        sweep_last_next = sect_base | MEM_AW'(SECT_MASK);
                    end
                end
            end
            fbce_pkg::ST_READ: begin
                m_valid_next = 1'b1;
                m_err_next   = 1'b0;
                case (rsel_reg)
                    fbce_pkg::RSEL_MFR: m_rdata_next = mfr_id_reg;
                    fbce_pkg::RSEL_DEV: m_rdata_next = dev_id_reg;
                    default:            m_rdata_next = mem_rd_reg;
                endcase
            end
            default: s_tready = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= fbce_pkg::ST_CLEAR;
            phase_reg      <= fbce_pkg::PH_READY;
            id_mode_reg    <= 1'b0;
            bank_reg       <= 1'b0;
            sweep_addr_reg <= '0;
            sweep_last_reg <= MEM_LAST;
            m_valid_reg    <= 1'b0;
            rsel_reg       <= fbce_pkg::RSEL_MEM;
        end else begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_last_reg <= sweep_last_next;
            m_valid_reg    <= m_valid_next;
            rsel_reg       <= rsel_next;
            if (wr_xfer) begin
                phase_reg   <= phase_next;
                id_mode_reg <= id_mode_next;
                bank_reg    <= bank_next;
            end
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        m_rdata_reg <= m_rdata_next;
        m_err_reg   <= m_err_next;
    end

    // Storage RAM with a registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rd_reg <= mem[mem_addr];
        end
    end

    // ID byte registers, written by the configuration port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mfr_id_reg <= fbce_pkg::MFR_ID_RST;
            dev_id_reg <= fbce_pkg::DEV_ID_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                fbce_pkg::REG_MFR_ID: mfr_id_reg <= pwdata[7:0];
                default:              dev_id_reg <= pwdata[7:0];
            endcase
        end
    end

    assign pready   = 1'b1;
    assign prdata   = {24'd0, (paddr[2] == fbce_pkg::REG_MFR_ID) ? mfr_id_reg : dev_id_reg};
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_err_reg, m_rdata_reg};

    // Checks on the engine's own sequencing.
    `FBCE_ASSERT_IMP(a_accept_frees_out, in_xfer, !m_valid_reg || m_tready, "accepted over a held result")
    `FBCE_ASSERT_NXT(a_read_loads_out, state_reg == fbce_pkg::ST_READ, m_valid_reg, "read result not loaded")
    `FBCE_ASSERT_IMP(a_port_single, mem_re, !mem_we, "RAM read and write in one cycle")
    `FBCE_ASSERT_IMP(a_sweep_in_range, state_reg == fbce_pkg::ST_ERASE, sweep_addr_reg <= sweep_last_reg, "sweep ran past its sector")
    `FBCE_ASSERT_IMP(a_busy_no_accept, state_reg != fbce_pkg::ST_IDLE, !s_tready, "accept while busy")

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the flash backup command engine top level.
`timescale 1ns / 1ps

module testbench;
    import fbce_pkg::*;

    localparam int NUM_DIRECTED     = 31;
    localparam int PHASE_ITEMS      = 268;
    localparam int NUM_PHASES       = 4;
    localparam int CALM_TAIL        = 120;
    localparam int LONG_HOLD_CYCLES = 400;
    // Reset clearing and a chip erase each sweep all 131072 bytes while no input is accepted.
    localparam int STALL_LIMIT      = 600000;
    localparam int FLASH_BYTES      = BANK_COUNT_DEF * BANK_BYTES;
    localparam logic [7:0] CMD_UNKNOWN = 8'h33;

    typedef struct packed {
        logic [7:0] read_data;
        logic       cmd_error;
    } access_result_t;

    typedef struct packed {
        logic           func;
        logic [15:0]    addr;
        logic [7:0]     data;
        logic           typed;
        access_result_t typed_res;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Typed expectation that travels alongside the current input transfer.
    logic           row_typed;
    access_result_t row_typed_res;

    // Private copy of the flash state and the ID registers.
    logic [7:0] flash_mem [0:FLASH_BYTES-1];
    phase_t     flash_phase;
    logic       id_mode;
    logic       bank_sel;
    logic [7:0] id_mfr;
    logic [7:0] id_dev;

    access_result_t awaited_responses [$];

    int  items_sent;
    int  mismatch_count;
    int  read_count;
    int  write_count;
    int  prologue_errors;
    int  sector_erases;
    int  chip_erases;
    int  bank_changes;
    int  id_settings;
    int  sector_budget;
    int  chip_budget;
    bit  bursts_enabled;
    bit  hold_request;

    // Directed accesses; typed results are those that are obvious from the spec.
    stim_row_t directed_rows [0:NUM_DIRECTED-1] = '{
        '{FUNC_READ,  ADDR_ZERO,    8'h00,      1'b1, '{ERASED, 1'b0}},
        '{FUNC_WRITE, ADDR_CMD1,    8'h00,      1'b1, '{8'h00, 1'b1}},
        '{FUNC_WRITE, ADDR_CMD1,    BYTE_PRO1,  1'b0, '{8'h00, 1'b0}},
        '{FUNC_WRITE, 16'h1234,     8'h5A,      1'b1, '{8'h00, 1'b0}},
        '{FUNC_WRITE, ADDR_CMD2,    8'hFF,      1'b1, '{8'h00, 1'b1}},
        '{FUNC_WRITE, ADDR_CMD2,    BYTE_PRO2,  1'b0, '{8'h00, 1'b0}},
        '{FUNC_WRITE, ADDR_CMD1,    CMD_ID_IN,  1'b0, '{8'h00, 1'b0}},
        '{FUNC_READ,  ADDR_ZERO,    8'h00,      1'b1, '{MFR_ID_RST, 1'b0}},
        '{FUNC_READ,  ADDR_ONE,     8'h00,      1'b1, '{DEV_ID_RST, 1'b0}},
        '{FUNC_WRITE, ADDR_CMD1,    BYTE_PRO1,  1'b0, '{8'h00, 1'b0}},
        '{FUNC_WRITE, ADDR_CMD2,    BYTE_PRO2,  1'b0, '{8'h00, 1'b0}},
        '{FUNC_WRITE, ADDR_CMD1,    CMD_PROG,   1'b0, '{8'h00, 1'b0}},
        '{FUNC_WRITE, 16'hFFFF,     8'h00,      1'b0, '{8'h00, 1'b0}},
        '{FUNC_READ,  16'hFFFF,     8'h00,      1'b0, '{8'h00, 1'b0}},
        '{FUNC_WRITE, ADDR_CMD1,    BYTE_PRO1,  1'b0, '{8'h00, 1'b0}},
        '{FUNC_WRITE, ADDR_CMD2,    BYTE_PRO2,  1'b0, '{8'h00, 1'b0}},
        '{FUNC_WRITE, 16'h0123,     8'h11,      1'b0, '{8'h00, 1'b0}},
        '{FUNC_WRITE, 16'hF000,     8'h00,      1'b0, '{8'h00, 1'b0}},
        '{FUNC_READ,  16'hFFFF,     8'h00,      1'b0, '{8'h00, 1'b0}},
        '{FUNC_WRITE, ADDR_CMD1,    BYTE_PRO1,  1'b0, '{8'h00, 1'b0}},
        '{FUNC_WRITE, ADDR_CMD2,    BYTE_PRO2,  1'b0, '{8'h00, 1'b0}},
        '{FUNC_WRITE, ADDR_CMD1,    CMD_BANK,   1'b0, '{8'h00, 1'b0}},
        '{FUNC_WRITE, 16'h0007,     8'h01,      1'b0, '{8'h00, 1'b0}},
        '{FUNC_WRITE, ADDR_ZERO,    8'hFF,      1'b0, '{8'h00, 1'b0}},
        '{FUNC_WRITE, ADDR_CMD1,    BYTE_PRO1,  1'b0, '{8'h00, 1'b0}},
        '{FUNC_WRITE, ADDR_CMD2,    BYTE_PRO2,  1'b0, '{8'h00, 1'b0}},
        '{FUNC_WRITE, ADDR_CMD1,    CMD_ID_OUT, 1'b0, '{8'h00, 1'b0}},
        '{FUNC_WRITE, ADDR_CMD1,    BYTE_PRO1,  1'b0, '{8'h00, 1'b0}},
        '{FUNC_WRITE, ADDR_CMD2,    BYTE_PRO2,  1'b0, '{8'h00, 1'b0}},
        '{FUNC_WRITE, ADDR_CMD1,    CMD_CHIP,   1'b0, '{8'h00, 1'b0}},
        '{FUNC_READ,  ADDR_ZERO,    8'h00,      1'b0, '{8'h00, 1'b0}}
    };

    flash_backup_command_engine_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Sets every byte of every bank to the erased value.
    function automatic void fill_erased();
        for (int i = 0; i < FLASH_BYTES; i++) flash_mem[i] = ERASED;
    endfunction

    // Byte offset of the bank currently selected.
    function automatic int bank_base();
        return (BANK_COUNT_DEF > 1) ? int'(bank_sel) * BANK_BYTES : 0;
    endfunction

    // Computes the response to one bus access and advances the flash state.
    function automatic access_result_t predict_bus_response(input logic func,
                                                            input logic [15:0] addr,
                                                            input logic [7:0] data);
        access_result_t res;
        logic           armed_now;
        int             base;
        int             len;
        res.read_data = 8'h00;
        res.cmd_error = 1'b0;
        armed_now     = 1'b0;

        if (func == FUNC_READ) begin
            read_count++;
            if (id_mode && addr == ADDR_ZERO) begin
                res.read_data = id_mfr;
            end else if (id_mode && addr == ADDR_ONE) begin
                res.read_data = id_dev;
            end else begin
                res.read_data = flash_mem[bank_base() + int'(addr)];
            end
            return res;
        end
        write_count++;

        // First prologue byte, or the command byte once the prologue is complete.
        if (addr == ADDR_CMD1) begin
            if (flash_phase == PH_READY) begin
                if (data != BYTE_PRO1) res.cmd_error = 1'b1;
                else flash_phase = PH_PROLOGUE;
            end else if (flash_phase == PH_OPERATION) begin
                flash_phase = PH_READY;
                case (data)
                    CMD_ID_IN:  id_mode = 1'b1;
                    CMD_ID_OUT: id_mode = 1'b0;
                    CMD_CHIP: begin
                        fill_erased();
                        chip_erases++;
                    end
                    CMD_PROG: begin
                        flash_phase = PH_PROGRAM;
                        armed_now   = 1'b1;
                    end
                    CMD_BANK:   flash_phase = PH_BANK;
                    default:    ;
                endcase
            end
        end

        // Second prologue byte.
        if (addr == ADDR_CMD2 && flash_phase == PH_PROLOGUE) begin
            if (data != BYTE_PRO2) res.cmd_error = 1'b1;
            else flash_phase = PH_OPERATION;
        end

        // A sector-aligned write with a command open erases that sector.
        if ((int'(addr) % SECTOR_BYTES_DEF) == 0 && flash_phase == PH_OPERATION) begin
            base = int'(addr) - (int'(addr) % SECTOR_BYTES_DEF);
            len  = SECTOR_BYTES_DEF;
            if (base + len > BANK_BYTES) len = BANK_BYTES - base;
            for (int i = 0; i < len; i++) flash_mem[bank_base() + base + i] = ERASED;
            flash_phase = PH_READY;
            sector_erases++;
        end

        // Armed single-byte program stores the data as given.
        if (flash_phase == PH_PROGRAM && !armed_now) begin
            flash_mem[bank_base() + int'(addr)] = data;
            flash_phase = PH_READY;
        end

        // Armed bank select only reacts to address zero.
        if (flash_phase == PH_BANK && addr == ADDR_ZERO) begin
            bank_sel    = (BANK_COUNT_DEF > 1) ? data[0] : 1'b0;
            flash_phase = PH_READY;
            bank_changes++;
        end

        if (res.cmd_error) prologue_errors++;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input access_result_t want,
                                   input access_result_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("Mismatch (%s) at %0t: expected read_data=%02h cmd_error=%0d",
                     what, $realtime, want.read_data, want.cmd_error);
            $display("    got read_data=%02h cmd_error=%0d",
                     got.read_data, got.cmd_error);
        end
    endtask

    // Observe transfers on all ports: register writes, results, then new accesses.
    always @(posedge aclk) begin
        access_result_t got;
        access_result_t want;
        access_result_t predicted;
        if (aresetn) begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_MFR_ID) id_mfr = pwdata[7:0];
                else id_dev = pwdata[7:0];
            end
            if (m_tvalid && m_tready) begin
                got.read_data = m_tdata[7:0];
                got.cmd_error = m_tdata[8];
                if (awaited_responses.size() == 0) begin
                    report_mismatch("no access outstanding", '0, got);
                end else begin
                    want = awaited_responses.pop_front();
                    if (got.read_data !== want.read_data || got.cmd_error !== want.cmd_error) begin
                        report_mismatch("result fields", want, got);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predicted = predict_bus_response(s_tdata[0], s_tdata[16:1], s_tdata[24:17]);
                awaited_responses.push_back(row_typed ? row_typed_res : predicted);
            end
        end
    end

    // Offers one access on the input stream and waits for its transfer.
    task automatic send_row(input stim_row_t row);
        if (bursts_enabled && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid      <= 1'b1;
        s_tdata       <= {7'd0, row.data, row.addr, row.func};
        row_typed     <= row.typed;
        row_typed_res <= row.typed_res;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic bus_write(input logic [15:0] addr, input logic [7:0] data);
        send_row('{FUNC_WRITE, addr, data, 1'b0, '{8'h00, 1'b0}});
    endtask

    task automatic bus_read(input logic [15:0] addr);
        send_row('{FUNC_READ, addr, 8'h00, 1'b0, '{8'h00, 1'b0}});
    endtask

    task automatic open_command();
        bus_write(ADDR_CMD1, BYTE_PRO1);
        bus_write(ADDR_CMD2, BYTE_PRO2);
    endtask

    // Register write on the configuration port: setup phase, then access phase.
    task automatic apb_write(input logic [2:0] addr, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {24'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Addresses that programs and reads share, so that reads hit written bytes.
    function automatic logic [15:0] hot_addr();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return 16'($urandom_range(0, 3));
            2:       return 16'hFFFF - 16'($urandom_range(0, 3));
            default: return (16'($urandom_range(0, 15)) << 12) + 16'($urandom_range(0, 7));
        endcase
    endfunction

    // Address that is neither zero, the command address nor sector-aligned.
    function automatic logic [15:0] junk_addr();
        logic [15:0] a;
        a = 16'($urandom);
        if ((int'(a) % SECTOR_BYTES_DEF) == 0) a[0] = 1'b1;
        if (a == ADDR_CMD1) a = ADDR_CMD1 + 16'd1;
        return a;
    endfunction

    // One random sequence: mostly well-formed commands, the rest noise and broken prologues.
    task automatic random_sequence();
        int          pick;
        logic [7:0]  d;
        logic [15:0] a;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            bus_read(hot_addr());
        end else if (pick < 20) begin
            bus_write(16'($urandom), 8'($urandom));
        end else if (pick < 25) begin
            d = 8'($urandom);
            if (d == BYTE_PRO1) d = ~d;
            bus_write(ADDR_CMD1, d);
        end else if (pick < 30) begin
            // Broken second prologue byte and stray writes while it is awaited.
            bus_write(ADDR_CMD1, BYTE_PRO1);
            repeat ($urandom_range(0, 3)) begin
                if ($urandom_range(0, 1) == 1) begin
                    d = 8'($urandom);
                    if (d == BYTE_PRO2) d = ~d;
                    bus_write(ADDR_CMD2, d);
                end else begin
                    bus_write(junk_addr(), 8'($urandom));
                end
            end
            if ($urandom_range(0, 1) == 1) bus_write(ADDR_CMD2, BYTE_PRO2);
        end else begin
            open_command();
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                bus_write(ADDR_CMD1, CMD_ID_IN);
            end else if (pick < 20) begin
                bus_write(ADDR_CMD1, CMD_ID_OUT);
            end else if (pick < 50) begin
                bus_write(ADDR_CMD1, CMD_PROG);
                a = hot_addr();
                bus_write(a, 8'($urandom));
                if ($urandom_range(0, 1) == 1) bus_read(a);
            end else if (pick < 65) begin
                bus_write(ADDR_CMD1, CMD_BANK);
                repeat ($urandom_range(0, 2)) bus_write(junk_addr(), 8'($urandom));
                bus_write(ADDR_ZERO, 8'($urandom));
            end else if (pick < 72 && sector_budget > 0) begin
                sector_budget--;
                a = 16'($urandom_range(0, 15)) << 12;
                bus_write(a, 8'($urandom));
                bus_read(a + 16'($urandom_range(0, 7)));
            end else if (pick < 73 && chip_budget > 0) begin
                chip_budget--;
                bus_write(ADDR_CMD1, CMD_CHIP);
            end else if (pick < 85) begin
                d = 8'($urandom);
                if (d == CMD_ID_IN || d == CMD_ID_OUT || d == CMD_CHIP || d == CMD_PROG ||
                    d == CMD_BANK) d = CMD_UNKNOWN;
                bus_write(ADDR_CMD1, d);
            end else begin
                // Leaves the command open for whatever follows.
                bus_write(junk_addr(), 8'($urandom));
            end
        end
    endtask

    // Result side: random stall bursts and one long hold-off on request.
    initial begin
        int hold_count;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_tready   <= 1'b0;
                hold_count = 0;
                while (hold_count < LONG_HOLD_CYCLES) begin
                    @(posedge aclk);
                    hold_count++;
                end
                hold_request = 1'b0;
                m_tready <= 1'b1;
            end else if (bursts_enabled && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Ends the run when no transfer happens for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("** flash_backup_command_engine_top: FAILED **");
        $finish;
    end

    // Main sequence: reset, directed rows, then random phases with new ID settings.
    initial begin
        logic [7:0] cfg_mfr;
        logic [7:0] cfg_dev;
        int         leftover;
        items_sent      = 0;
        mismatch_count  = 0;
        read_count      = 0;
        write_count     = 0;
        prologue_errors = 0;
        sector_erases   = 0;
        chip_erases     = 0;
        bank_changes    = 0;
        id_settings     = 0;
        sector_budget   = 24;
        chip_budget     = 1;
        bursts_enabled  = 1'b1;
        hold_request    = 1'b0;
        fill_erased();
        flash_phase = PH_READY;
        id_mode     = 1'b0;
        bank_sel    = 1'b0;
        id_mfr      = MFR_ID_RST;
        id_dev      = DEV_ID_RST;

        aresetn       <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        row_typed     <= 1'b0;
        row_typed_res <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) send_row(directed_rows[i]);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // Registers change only once every outstanding result has come back.
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while (awaited_responses.size() != 0) @(posedge aclk);
            case (ph)
                0: begin
                    cfg_mfr = 8'h00;
                    cfg_dev = 8'hFF;
                end
                1: begin
                    cfg_mfr = 8'hFF;
                    cfg_dev = 8'h00;
                end
                default: begin
                    cfg_mfr = 8'($urandom);
                    cfg_dev = 8'($urandom);
                end
            endcase
            apb_write({REG_MFR_ID, 2'b00}, cfg_mfr);
            apb_write({REG_DEV_ID, 2'b00}, cfg_dev);
            id_settings++;
            if (ph == 1) hold_request = 1'b1;
            while (items_sent < NUM_DIRECTED + (ph + 1) * PHASE_ITEMS) begin
                if (items_sent >= NUM_DIRECTED + NUM_PHASES * PHASE_ITEMS - CALM_TAIL) begin
                    bursts_enabled = 1'b0;
                end
                random_sequence();
            end
        end

        // Drain the results, then allow for the read latency.
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (awaited_responses.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        leftover = awaited_responses.size();

        $display("Covered %0d reads and %0d writes with %0d prologue errors, %0d sector erases,",
                 read_count, write_count, prologue_errors, sector_erases);
        $display("%0d chip erases, %0d bank selects and %0d ID byte settings; %0d mismatches.",
                 chip_erases, bank_changes, id_settings, mismatch_count);
        if (mismatch_count == 0 && leftover == 0) begin
            $display("** flash_backup_command_engine_top: PASSED **");
        end else begin
            $display("** flash_backup_command_engine_top: FAILED **");
        end
        $finish;
    end

endmodule
